// ----- sv/occ_pkg.sv -----
// occupancy grid builder package: sizes, codes, queue item and state types
// and the disk helper functions used by the back end
// no dependencies
package occ_pkg;

    localparam int MAX_POINTS  = 4096;
    localparam int PT_IDX_W    = 12;
    localparam int PT_CNT_W    = 13;
    localparam int GRID_COLS   = 256;
    localparam int GRID_ROWS   = 256;
    localparam int CELL_W      = 8;
    localparam int SIZE_W      = 9;
    localparam int MAX_RADIUS  = 15;
    localparam int RAD_W       = 4;
    localparam int COORD_W     = 32;
    localparam int RES_W       = 21;
    localparam int QUOT_W      = 8;
    localparam int STEP_W      = 3;
    localparam int DIV_W       = RES_W + QUOT_W;
    localparam int SPAN_W      = COORD_W + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [RES_W-1:0] RES_RESET = 21'd3277;
    localparam logic [RAD_W-1:0] RAD_RESET = 4'd1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    localparam logic CFG_RESOLUTION = 1'b0;
    localparam logic CFG_RADIUS     = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_BUILD,
        CMD_READ
    } t_cmd;

    typedef struct packed {
        t_cmd                       cmd;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [CELL_W-1:0]          col;
        logic [CELL_W-1:0]          row;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OUT,
        S_B_START,
        S_B_SIZE,
        S_B_SWAIT,
        S_B_CLEAR,
        S_P_RD,
        S_P_START,
        S_P_WAIT,
        S_P_MARK,
        S_D_START,
        S_D_RD,
        S_D_ACC,
        S_D_WR,
        S_B_OUT
    } t_state;

    // widest horizontal reach k with k*k + d*d <= r*r
    function automatic logic [RAD_W-1:0] half_width(input logic [RAD_W-1:0] r,
                                                    input logic [RAD_W-1:0] d);
        logic [RAD_W-1:0] k;
        k = '0;
        for (int i = 0; i <= MAX_RADIUS; i++) begin
            if (i * i + int'(d) * int'(d) <= int'(r) * int'(r)) begin
                k = RAD_W'(i);
            end
        end
        return k;
    endfunction

    // row dilated left and right by k cells
    function automatic logic [GRID_COLS-1:0] spread_row(input logic [GRID_COLS-1:0] row,
                                                        input logic [RAD_W-1:0] k);
        logic [GRID_COLS-1:0] o;
        o = '0;
        for (int i = 0; i < GRID_COLS; i++) begin
            for (int j = -MAX_RADIUS; j <= MAX_RADIUS; j++) begin
                if ((i + j >= 0) && (i + j < GRID_COLS) &&
                    (((j < 0) ? -j : j) <= int'(k))) begin
                    o[i] = o[i] | row[i + j];
                end
            end
        end
        return o;
    endfunction

endpackage

// ----- sv/occ_front.sv -----
// front end: takes input transfers, drops unknown operations and turns
// the rest into queue items; depends on occ_pkg
module occ_front import occ_pkg::*; (
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic [CELL_W-1:0]         i_col,
    input  logic [CELL_W-1:0]         i_row,
    input  t_q_flags                  i_q_flags,
    output logic                      o_push,
    output t_item                     o_item
);

    logic w_known;

    assign o_in_stall = i_q_flags.full;

    always_comb begin
        w_known    = 1'b1;
        o_item.cmd = CMD_LOAD;
        unique case (i_operation)
            OP_LOAD:  o_item.cmd = CMD_LOAD;
            OP_BUILD: o_item.cmd = CMD_BUILD;
            OP_READ:  o_item.cmd = CMD_READ;
            default:  w_known    = 1'b0;
        endcase
        o_item.x   = i_x_coord;
        o_item.y   = i_y_coord;
        o_item.col = i_col;
        o_item.row = i_row;
    end

    // unknown operation: the transfer completes and nothing is queued
    assign o_push = i_in_valid && !i_q_flags.full && w_known;

endmodule

// ----- sv/occ_queue.sv -----
// short command queue between front and back end
// depends on occ_pkg
module occ_queue import occ_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_item    i_item,
    input  logic     i_pop,
    output t_item    o_head,
    output t_q_flags o_flags
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_flags.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_flags.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

// ----- sv/occ_div.sv -----
// serial restoring divider, one quotient bit a cycle; the caller keeps the
// dividend below divisor * 2^QUOT_W; depends on occ_pkg
module occ_div import occ_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_W-1:0]  i_dividend,
    input  logic [RES_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot,
    output logic              o_rem_nz
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_quot;
    logic [DIV_W-1:0]  w_trial;
    logic              w_fits;

    assign w_trial  = DIV_W'(i_divisor) << r_step;
    assign w_fits   = (r_rem >= w_trial);
    assign o_done   = r_done;
    assign o_quot   = r_quot;
    assign o_rem_nz = (r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(QUOT_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_dividend;
            r_quot <= '0;
        end else if (r_busy && w_fits) begin
            r_rem          <= r_rem - w_trial;
            r_quot[r_step] <= 1'b1;
        end
    end

endmodule

// ----- sv/occ_back.sv -----
// back end: point store, bounding box, grid build sequencer, raw and
// dilated grid memories and the result register; depends on occ_pkg, occ_div
module occ_back import occ_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [RES_W-1:0]          i_cfg_data,
    input  t_item                     i_head,
    input  t_q_flags                  i_q_flags,
    output logic                      o_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SIZE_W-1:0]         o_grid_width,
    output logic [SIZE_W-1:0]         o_grid_height,
    output logic signed [COORD_W-1:0] o_origin_x,
    output logic signed [COORD_W-1:0] o_origin_y,
    output logic [1:0]                o_status,
    output logic                      o_occupied,
    output logic [PT_CNT_W-1:0]       o_point_count
);

    t_state r_state, n_state;

    logic [RES_W-1:0]          r_res;
    logic [RAD_W-1:0]          r_rad;
    logic [PT_CNT_W-1:0]       r_total;
    logic                      r_ovf;
    logic signed [COORD_W-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic [SIZE_W-1:0]         r_built_w, r_built_h;
    logic                      r_out_valid;

    logic [2*COORD_W-1:0]      point_mem [MAX_POINTS];
    logic [GRID_COLS-1:0]      raw_mem   [GRID_ROWS];
    logic [GRID_COLS-1:0]      dil_mem   [GRID_ROWS];
    logic [2*COORD_W-1:0]      r_pt_rd;
    logic [GRID_COLS-1:0]      r_raw_rd;
    logic [GRID_COLS-1:0]      r_dil_rd;

    logic [RES_W-1:0]          r_res_eff;
    logic [RAD_W-1:0]          r_rad_b;
    logic [SPAN_W-1:0]         r_span_x, r_span_y;
    logic [DIV_W-1:0]          r_lim;
    logic [1:0]                r_bstat;
    logic [SIZE_W-1:0]         r_cnt;
    logic [PT_CNT_W-1:0]       r_idx;
    logic signed [RAD_W:0]     r_dy;
    logic [GRID_COLS-1:0]      r_acc;
    logic [CELL_W-1:0]         r_cx, r_cy;
    logic [CELL_W-1:0]         r_col;
    logic                      r_in_range;

    logic                      w_slot_free;
    logic                      w_emit;
    logic                      w_load, w_read, w_build;
    logic                      w_pt_we, w_pt_re;
    logic                      w_raw_we, w_raw_re, w_dil_we, w_dil_re;
    logic [CELL_W-1:0]         w_raw_waddr, w_raw_raddr;
    logic [GRID_COLS-1:0]      w_raw_wdata;
    logic                      w_div_start;
    logic [DIV_W-1:0]          w_div_a_x, w_div_a_y;
    logic                      w_done_x, w_done_y;
    logic [QUOT_W-1:0]         w_quot_x, w_quot_y;
    logic                      w_rnz_x, w_rnz_y;
    logic [RES_W-1:0]          w_res_eff;
    logic [SPAN_W-1:0]         w_span_x, w_span_y, w_dx, w_dy;
    logic                      w_big;
    logic signed [SIZE_W:0]    w_ny;
    logic                      w_ny_ok;
    logic signed [RAD_W:0]     w_rad_s, w_dy_neg;
    logic [RAD_W-1:0]          w_dy_abs;
    logic                      w_dy_last;
    logic signed [COORD_W-1:0] w_px, w_py;

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_load  = !i_q_flags.empty && (i_head.cmd == CMD_LOAD);
    assign w_read  = !i_q_flags.empty && (i_head.cmd == CMD_READ);
    assign w_build = !i_q_flags.empty && (i_head.cmd == CMD_BUILD);

    assign w_res_eff = (r_res == '0) ? RES_W'(1) : r_res;
    assign w_span_x  = {r_max_x[COORD_W-1], r_max_x} - {r_min_x[COORD_W-1], r_min_x};
    assign w_span_y  = {r_max_y[COORD_W-1], r_max_y} - {r_min_y[COORD_W-1], r_min_y};
    // span above 255 cells gives a size beyond the grid
    assign w_big = (r_span_x > SPAN_W'(r_lim)) || (r_span_y > SPAN_W'(r_lim));

    assign w_px = r_pt_rd[2*COORD_W-1:COORD_W];
    assign w_py = r_pt_rd[COORD_W-1:0];
    assign w_dx = {w_px[COORD_W-1], w_px} - {r_min_x[COORD_W-1], r_min_x};
    assign w_dy = {w_py[COORD_W-1], w_py} - {r_min_y[COORD_W-1], r_min_y};

    assign w_rad_s   = $signed({1'b0, r_rad_b});
    assign w_dy_neg  = -r_dy;
    assign w_dy_abs  = r_dy[RAD_W] ? w_dy_neg[RAD_W-1:0] : r_dy[RAD_W-1:0];
    assign w_dy_last = (r_dy == w_rad_s);
    assign w_ny      = $signed({1'b0, r_cnt}) + $signed({{(SIZE_W-RAD_W){r_dy[RAD_W]}}, r_dy});
    assign w_ny_ok   = !w_ny[SIZE_W] && (w_ny[SIZE_W-1:0] < r_built_h);

    occ_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a_x),
        .i_divisor  (r_res_eff),
        .o_done     (w_done_x),
        .o_quot     (w_quot_x),
        .o_rem_nz   (w_rnz_x)
    );

    occ_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a_y),
        .i_divisor  (r_res_eff),
        .o_done     (w_done_y),
        .o_quot     (w_quot_y),
        .o_rem_nz   (w_rnz_y)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_build) begin
                    n_state = S_B_START;
                end else if (w_read) begin
                    n_state = S_RD_OUT;
                end
            end
            S_RD_OUT:  if (w_slot_free) n_state = S_IDLE;
            S_B_START: n_state = (r_total == '0) ? S_B_OUT : S_B_SIZE;
            S_B_SIZE:  n_state = w_big ? S_B_OUT : S_B_SWAIT;
            S_B_SWAIT: if (w_done_x && w_done_y) n_state = S_B_CLEAR;
            S_B_CLEAR: if (r_cnt + 1'b1 == r_built_h) n_state = S_P_RD;
            S_P_RD:    n_state = S_P_START;
            S_P_START: n_state = S_P_WAIT;
            S_P_WAIT:  if (w_done_x && w_done_y) n_state = S_P_MARK;
            S_P_MARK:  n_state = (r_idx + 1'b1 == r_total) ? S_D_START : S_P_RD;
            S_D_START: n_state = S_D_RD;
            S_D_RD: begin
                if (w_ny_ok) begin
                    n_state = S_D_ACC;
                end else if (w_dy_last) begin
                    n_state = S_D_WR;
                end
            end
            S_D_ACC:   n_state = w_dy_last ? S_D_WR : S_D_RD;
            S_D_WR:    n_state = (r_cnt + 1'b1 == r_built_h) ? S_B_OUT : S_D_START;
            S_B_OUT:   if (w_slot_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop       = 1'b0;
        w_emit      = 1'b0;
        w_pt_we     = 1'b0;
        w_pt_re     = 1'b0;
        w_raw_we    = 1'b0;
        w_raw_re    = 1'b0;
        w_dil_we    = 1'b0;
        w_dil_re    = 1'b0;
        w_raw_waddr = r_cy;
        w_raw_wdata = r_raw_rd | (GRID_COLS'(1) << r_cx);
        w_raw_raddr = w_ny[CELL_W-1:0];
        w_div_start = 1'b0;
        w_div_a_x   = w_dx[DIV_W-1:0];
        w_div_a_y   = w_dy[DIV_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                o_pop    = !i_q_flags.empty;
                w_pt_we  = w_load && !r_total[PT_CNT_W-1];
                w_dil_re = w_read;
            end
            S_RD_OUT: w_emit = w_slot_free;
            S_B_SIZE: begin
                w_div_start = !w_big;
                w_div_a_x   = r_span_x[DIV_W-1:0];
                w_div_a_y   = r_span_y[DIV_W-1:0];
            end
            S_B_CLEAR: begin
                w_raw_we    = 1'b1;
                w_raw_waddr = r_cnt[CELL_W-1:0];
                w_raw_wdata = '0;
            end
            S_P_RD:    w_pt_re = 1'b1;
            S_P_START: w_div_start = 1'b1;
            S_P_WAIT: begin
                w_raw_re    = w_done_x && w_done_y;
                w_raw_raddr = w_quot_y;
            end
            S_P_MARK:  w_raw_we = 1'b1;
            S_D_RD:    w_raw_re = w_ny_ok;
            S_D_WR:    w_dil_we = 1'b1;
            S_B_OUT:   w_emit = w_slot_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res       <= RES_RESET;
            r_rad       <= RAD_RESET;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_min_x     <= {1'b0, {(COORD_W-1){1'b1}}};
            r_min_y     <= {1'b0, {(COORD_W-1){1'b1}}};
            r_max_x     <= {1'b1, {(COORD_W-1){1'b0}}};
            r_max_y     <= {1'b1, {(COORD_W-1){1'b0}}};
            r_built_w   <= '0;
            r_built_h   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RESOLUTION) begin
                    r_res <= i_cfg_data;
                end else begin
                    r_rad <= i_cfg_data[RAD_W-1:0];
                end
            end
            if (r_state == S_IDLE && w_load) begin
                if (r_total[PT_CNT_W-1]) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_total <= r_total + 1'b1;
                    if (i_head.x < r_min_x) r_min_x <= i_head.x;
                    if (i_head.x > r_max_x) r_max_x <= i_head.x;
                    if (i_head.y < r_min_y) r_min_y <= i_head.y;
                    if (i_head.y > r_max_y) r_max_y <= i_head.y;
                end
            end
            if (r_state == S_B_START) begin
                r_built_w <= '0;
                r_built_h <= '0;
            end
            if (r_state == S_B_SWAIT && w_done_x && w_done_y) begin
                r_built_w <= {1'b0, w_quot_x} + SIZE_W'(w_rnz_x) + 1'b1;
                r_built_h <= {1'b0, w_quot_y} + SIZE_W'(w_rnz_y) + 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // build datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_col      <= i_head.col;
                r_in_range <= ({1'b0, i_head.col} < r_built_w) &&
                              ({1'b0, i_head.row} < r_built_h);
            end
            S_B_START: begin
                r_res_eff <= w_res_eff;
                r_lim     <= (DIV_W'(w_res_eff) << QUOT_W) - DIV_W'(w_res_eff);
                r_span_x  <= w_span_x;
                r_span_y  <= w_span_y;
                r_rad_b   <= r_rad;
                r_bstat   <= ST_EMPTY;
            end
            S_B_SIZE: begin
                r_bstat <= w_big ? ST_TOO_LARGE : (r_ovf ? ST_DROPPED : ST_OK);
                r_cnt   <= '0;
                r_idx   <= '0;
            end
            S_B_CLEAR: r_cnt <= r_cnt + 1'b1;
            S_P_WAIT: begin
                r_cx <= w_quot_x;
                r_cy <= w_quot_y;
            end
            S_P_MARK: begin
                r_idx <= r_idx + 1'b1;
                r_cnt <= '0;
            end
            S_D_START: begin
                r_dy  <= -w_rad_s;
                r_acc <= '0;
            end
            S_D_RD: if (!w_ny_ok) r_dy <= r_dy + 1'b1;
            S_D_ACC: begin
                r_acc <= r_acc | spread_row(r_raw_rd, half_width(r_rad_b, w_dy_abs));
                r_dy  <= r_dy + 1'b1;
            end
            S_D_WR: r_cnt <= r_cnt + 1'b1;
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_grid_width  <= r_built_w;
            o_grid_height <= r_built_h;
            if (r_state == S_RD_OUT) begin
                o_origin_x    <= '0;
                o_origin_y    <= '0;
                o_status      <= ST_OK;
                o_occupied    <= r_in_range & r_dil_rd[r_col];
                o_point_count <= '0;
            end else begin
                o_origin_x    <= (r_bstat == ST_EMPTY) ? '0 : r_min_x;
                o_origin_y    <= (r_bstat == ST_EMPTY) ? '0 : r_min_y;
                o_status      <= r_bstat;
                o_occupied    <= 1'b0;
                o_point_count <= r_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            point_mem[r_total[PT_IDX_W-1:0]] <= {i_head.x, i_head.y};
        end
        if (w_pt_re) begin
            r_pt_rd <= point_mem[r_idx[PT_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_raw_we) begin
            raw_mem[w_raw_waddr] <= w_raw_wdata;
        end
        if (w_raw_re) begin
            r_raw_rd <= raw_mem[w_raw_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dil_we) begin
            dil_mem[r_cnt[CELL_W-1:0]] <= r_acc;
        end
        if (w_dil_re) begin
            r_dil_rd <= dil_mem[i_head.row];
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/occupancy_grid_builder.sv -----
// a load is queued and then written to the point store when the idle back end takes it,
// a read result is offered after one dilated grid row read and the result register
// build time is set by the serial 8-step dividers per point
// and one raw row read per disk row
// loads take one transfer a cycle while the queue has room; one item is worked at a time
// reset: synchronous, active low; no clearing pass, grids are written by each nonempty build that fits the grid
module occupancy_grid_builder import occ_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [RES_W-1:0]          i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_operation,
    input  logic signed [COORD_W-1:0] i_x_coord,
    input  logic signed [COORD_W-1:0] i_y_coord,
    input  logic [CELL_W-1:0]         i_col,
    input  logic [CELL_W-1:0]         i_row,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [SIZE_W-1:0]         o_grid_width,
    output logic [SIZE_W-1:0]         o_grid_height,
    output logic signed [COORD_W-1:0] o_origin_x,
    output logic signed [COORD_W-1:0] o_origin_y,
    output logic [1:0]                o_status,
    output logic                      o_occupied,
    output logic [PT_CNT_W-1:0]       o_point_count
);

    logic     w_push;
    logic     w_pop;
    t_item    w_item;
    t_item    w_head;
    t_q_flags w_flags;

    occ_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_x_coord   (i_x_coord),
        .i_y_coord   (i_y_coord),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_q_flags   (w_flags),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    occ_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_flags (w_flags)
    );

    occ_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_head        (w_head),
        .i_q_flags     (w_flags),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_grid_width  (o_grid_width),
        .o_grid_height (o_grid_height),
        .o_origin_x    (o_origin_x),
        .o_origin_y    (o_origin_y),
        .o_status      (o_status),
        .o_occupied    (o_occupied),
        .o_point_count (o_point_count)
    );

endmodule

// ----- sv/occ_checker.sv -----
// port-level checks for the occupancy grid builder, bound to the top level
// depends on occ_pkg
module occ_checker import occ_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [SIZE_W-1:0]         o_grid_width,
    input logic [SIZE_W-1:0]         o_grid_height,
    input logic [1:0]                o_status,
    input logic                      o_occupied,
    input logic [PT_CNT_W-1:0]       o_point_count
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn under stall");

    // an occupied cell only comes from a read of a built grid
    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_occupied |->
            o_status == ST_OK && o_point_count == '0 && o_grid_width != '0)
        else $error("occupied cell outside a read of a built grid");

    // an empty build reports no size and no points
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_EMPTY |->
            o_grid_width == '0 && o_grid_height == '0 && o_point_count == '0)
        else $error("empty build with size or points");

    // a rejected grid reports no size
    a_large: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_TOO_LARGE |->
            o_grid_width == '0 && o_grid_height == '0 && o_point_count != '0)
        else $error("oversized grid reported with a size");

endmodule

bind occupancy_grid_builder occ_checker u_checker (.*);
